[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the circle outline generator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define COG_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("circle outline generator: assertion failed");

// The antecedent implies the consequent in the following cycle.
`define COG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("circle outline generator: sequencing assertion failed");

`endif

[rtl/core/cog_pkg.sv]
// ----------------------------------------------------------------------------
// Circle outline generator package
// Shared types and constants of the circle outline generator.
// ----------------------------------------------------------------------------
package cog_pkg;

  localparam int unsigned RadiusBitsDef = 12;
  localparam int unsigned CoordW        = 16;
  localparam int unsigned RadiusInW     = 12;
  localparam int unsigned ErrW          = 16;
  localparam int unsigned PointCnt      = 8;
  localparam int unsigned PointIdxW     = $clog2(PointCnt);

  typedef enum logic {
    MODE_START = 1'b0,
    MODE_NEXT  = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e                mode;
    logic [CoordW-1:0]    center_x;
    logic [CoordW-1:0]    center_y;
    logic [RadiusInW-1:0] radius;
  } in_item_t;

  typedef struct packed {
    logic [CoordW-1:0] point_x;
    logic [CoordW-1:0] point_y;
    logic              last;
  } out_item_t;

endpackage

[rtl/core/cog_stepper.sv]
// ----------------------------------------------------------------------------
// Circle outline stepper
// Takes input beats, advances the midpoint error stepper and registers one
// set of offsets per step for the point emitter.
// ----------------------------------------------------------------------------
module cog_stepper #(
  parameter int unsigned RADIUS_BITS = cog_pkg::RadiusBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  cog_pkg::in_item_t            in_item_i,
  output logic                         set_valid_o,
  input  logic                         set_take_i,
  output logic [cog_pkg::CoordW-1:0]   set_cx_o,
  output logic [cog_pkg::CoordW-1:0]   set_cy_o,
  output logic [RADIUS_BITS-1:0]       set_minor_o,
  output logic [RADIUS_BITS-1:0]       set_major_o,
  output logic                         set_last_o
);
  import cog_pkg::*;

  logic                   active_q, active_d;
  logic [CoordW-1:0]      cx_q, cy_q;
  logic [RADIUS_BITS-1:0] minor_q, major_q;
  logic [ErrW-1:0]        err_q;

  logic                   set_valid_q, set_valid_d;
  logic [CoordW-1:0]      set_cx_q, set_cy_q;
  logic [RADIUS_BITS-1:0] set_minor_q, set_major_q;
  logic                   set_last_q;

  logic                        accept, is_start, produce;
  logic [RADIUS_BITS+RadiusInW-1:0] rad_wide;
  logic [RADIUS_BITS-1:0]      rad;
  logic [CoordW-1:0]           cur_cx, cur_cy;
  logic [RADIUS_BITS-1:0]      cur_minor, cur_major, major_n;
  logic [ErrW-1:0]             cur_err, err_n, inc;
  logic [RADIUS_BITS:0]        minor_n;
  logic                        done;

  assign in_stall_o = set_valid_q && !set_take_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_start   = (in_item_i.mode == MODE_START);
  assign produce    = accept && (is_start || active_q);

  assign rad_wide = {{RADIUS_BITS{1'b0}}, in_item_i.radius};
  assign rad      = rad_wide[RADIUS_BITS-1:0];

  always_comb begin
    cur_cx    = is_start ? in_item_i.center_x : cx_q;
    cur_cy    = is_start ? in_item_i.center_y : cy_q;
    cur_minor = is_start ? '0 : minor_q;
    cur_major = is_start ? rad : major_q;
    cur_err   = is_start ? '0 : err_q;

    minor_n = {1'b0, cur_minor} + (RADIUS_BITS+1)'(1);
    inc     = (ErrW'(minor_n) << 1) | ErrW'(1);
    major_n = cur_major;
    err_n   = cur_err;
    done    = 1'b0;
    if (cur_err[ErrW-1]) begin
      err_n = cur_err + inc;
    end else if (cur_major == '0) begin
      // Major offset zero: never step it below zero.
      done = 1'b1;
    end else begin
      major_n = cur_major - RADIUS_BITS'(1);
      err_n   = cur_err + inc - (ErrW'(major_n) << 1);
    end
    if (minor_n > {1'b0, major_n}) begin
      done = 1'b1;
    end
  end

  always_comb begin
    active_d    = active_q;
    set_valid_d = set_valid_q;
    if (set_take_i) begin
      set_valid_d = 1'b0;
    end
    if (produce) begin
      active_d    = !done;
      set_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      set_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      set_valid_q <= set_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) begin
      cx_q        <= cur_cx;
      cy_q        <= cur_cy;
      minor_q     <= minor_n[RADIUS_BITS-1:0];
      major_q     <= major_n;
      err_q       <= err_n;
      set_cx_q    <= cur_cx;
      set_cy_q    <= cur_cy;
      set_minor_q <= cur_minor;
      set_major_q <= cur_major;
      set_last_q  <= done;
    end
  end

  assign set_valid_o = set_valid_q;
  assign set_cx_o    = set_cx_q;
  assign set_cy_o    = set_cy_q;
  assign set_minor_o = set_minor_q;
  assign set_major_o = set_major_q;
  assign set_last_o  = set_last_q;

endmodule

[rtl/core/cog_emitter.sv]
// ----------------------------------------------------------------------------
// Circle outline point emitter
// Walks the eight mirrored points of one offset set into the output register.
// ----------------------------------------------------------------------------
module cog_emitter #(
  parameter int unsigned RADIUS_BITS = cog_pkg::RadiusBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         set_valid_i,
  output logic                         set_take_o,
  input  logic [cog_pkg::CoordW-1:0]   set_cx_i,
  input  logic [cog_pkg::CoordW-1:0]   set_cy_i,
  input  logic [RADIUS_BITS-1:0]       set_minor_i,
  input  logic [RADIUS_BITS-1:0]       set_major_i,
  input  logic                         set_last_i,
  output logic                         busy_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output cog_pkg::out_item_t           out_item_o
);
  import cog_pkg::*;

  localparam logic [PointIdxW-1:0] LastIdx = PointIdxW'(PointCnt - 1);

  logic                 busy_q, busy_d;
  logic [PointIdxW-1:0] idx_q;
  logic [CoordW-1:0]    cx_q, cy_q;
  logic [CoordW-1:0]    minor_q, major_q;
  logic                 last_q;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;

  logic              advance, final_pt;
  logic [CoordW-1:0] dx, dy;

  assign advance    = busy_q && (!out_valid_q || !out_stall_i);
  assign final_pt   = (idx_q == LastIdx);
  assign set_take_o = set_valid_i && (!busy_q || (advance && final_pt));

  // Index bit 2 swaps the offsets, bit 1 negates y, bit 0 negates x.
  always_comb begin
    dx = idx_q[2] ? major_q : minor_q;
    dy = idx_q[2] ? minor_q : major_q;
    out_d.point_x = idx_q[0] ? (cx_q - dx) : (cx_q + dx);
    out_d.point_y = idx_q[1] ? (cy_q - dy) : (cy_q + dy);
    out_d.last    = last_q && final_pt;
  end

  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      if (final_pt) begin
        busy_d = 1'b0;
      end
    end
    if (set_take_o) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      if (set_take_o) begin
        idx_q <= '0;
      end else if (advance) begin
        idx_q <= idx_q + PointIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (set_take_o) begin
      cx_q    <= set_cx_i;
      cy_q    <= set_cy_i;
      minor_q <= CoordW'(set_minor_i);
      major_q <= CoordW'(set_major_i);
      last_q  <= set_last_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign busy_o      = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[rtl/core/circle_outline_generator_unit.sv]
// ----------------------------------------------------------------------------
// Circle outline generator unit
// Midpoint circle rasterizer with eight-way octant symmetry.
// ----------------------------------------------------------------------------
// A start beat (mode 0) loads the center and radius and yields the eight
// mirrored points of the first step; each continue beat (mode 1) yields the
// next eight. The last flag is set on the eighth point of the final step,
// after which continue beats are taken and yield nothing until the next
// start. A start while a circle is in progress abandons it. Coordinates wrap
// modulo 65536. Every beat that yields points is walked out one point per
// cycle through the output register while the output is not stalled; a
// continue beat while idle is taken and yields no points. The stepper
// advances when the beat is taken and parks the offsets in a set register,
// so one step waits while the emitter walks the previous one; the first
// point of a beat passes from the set register through the emitter's
// offset registers into the output register.
`include "assert_macros.svh"

module circle_outline_generator_unit #(
  parameter int unsigned RADIUS_BITS = cog_pkg::RadiusBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cog_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cog_pkg::out_item_t out_item_o
);
  import cog_pkg::*;

  // Offset set handed from the stepper to the emitter.
  logic                   set_valid, set_take, set_last, emit_busy;
  logic [CoordW-1:0]      set_cx, set_cy;
  logic [RADIUS_BITS-1:0] set_minor, set_major;

  // High when a start beat is taken at this edge.
  logic                   in_start_take;

  assign in_start_take = in_valid_i && !in_stall_o && (in_item_i.mode == MODE_START);

  // The stepper owns the error term and the circle state.
  cog_stepper #(
    .RADIUS_BITS(RADIUS_BITS)
  ) u_stepper (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .set_valid_o (set_valid),
    .set_take_i  (set_take),
    .set_cx_o    (set_cx),
    .set_cy_o    (set_cy),
    .set_minor_o (set_minor),
    .set_major_o (set_major),
    .set_last_o  (set_last)
  );

  // The emitter mirrors one set into eight output beats.
  cog_emitter #(
    .RADIUS_BITS(RADIUS_BITS)
  ) u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .set_valid_i (set_valid),
    .set_take_o  (set_take),
    .set_cx_i    (set_cx),
    .set_cy_i    (set_cy),
    .set_minor_i (set_minor),
    .set_major_i (set_major),
    .set_last_i  (set_last),
    .busy_o      (emit_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // A start beat always produces a pending offset set.
  `COG_ASSERT_NEXT(a_start_makes_set, clk_i, rst_ni, in_start_take, set_valid)
  // A pending set is held until the emitter takes it.
  `COG_ASSERT_NEXT(a_set_held, clk_i, rst_ni, set_valid && !set_take, set_valid)
  // Taking a set always leaves the emitter busy.
  `COG_ASSERT_NEXT(a_take_busy, clk_i, rst_ni, set_take, emit_busy)
  // The emitter only takes a set that is pending.
  `COG_ASSERT(a_take_valid, clk_i, rst_ni, !set_take || set_valid)

endmodule
